### rtl/usph_pkg.sv
// shared constants and types for the uv sphere tessellator
package usph_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int QTR_SHIFT = ANGLE_BITS - 2;
	localparam logic [ANGLE_BITS-1:0] QTR_TURN = ANGLE_BITS'(64'd1 << QTR_SHIFT);
	localparam logic [ANGLE_BITS-1:0] THREE_QTR = ANGLE_BITS'(64'd3 << QTR_SHIFT);

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	localparam logic [10:0] MAX_DIVISIONS = 11'd1024;

	// series rounds: divisor and reciprocal shift of each
	localparam int NUM_ROUNDS = 5;
	localparam int RND_DIV [NUM_ROUNDS] = '{110, 72, 42, 20, 6};
	localparam int RND_SHIFT [NUM_ROUNDS] = '{38, 38, 37, 36, 34};

	typedef enum logic [2:0] {
		REG_RADIUS       = 3'd0,
		REG_AZIMUTH_STEP = 3'd1,
		REG_POLAR_STEP   = 3'd2,
		REG_SLICE_COUNT  = 3'd3,
		REG_STACK_COUNT  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [30:0] radius;
		logic [15:0] az_step;
		logic [15:0] polar_step;
		logic [10:0] slice_count;
		logic [10:0] stack_count;
	} cfg_t;

	typedef struct packed {
		logic last;
		logic err;
	} vtag_t;

	typedef struct packed {
		logic signed [15:0] cos_phi;
		logic signed [15:0] sin_phi;
		logic signed [15:0] sin_theta;
		logic signed [15:0] cos_theta;
	} trig_t;

endpackage

### rtl/uv_sphere_tessellator_core.sv
// top level of the uv sphere tessellator: config registers, pipeline and output skid
// throughput: one vertex per cycle while the skid holds no vertex; a word gives 1, 3 or 6
// vertices set by the vertex issue stage; a new word is taken on the cycle the previous word
// issues its last vertex
// reset: arst_n clears all valid bits and loads radius 1.0, both steps a quarter turn,
// 4 slices and 2 stacks
module uv_sphere_tessellator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [9:0]         slice_index,
	input  logic [9:0]         band_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic signed [31:0] vertex_z,
	output logic               last_vertex,
	output logic               index_error
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		usph_pkg::vtag_t    tag;
	} vout_t;

	usph_pkg::cfg_t  cfg_q;
	logic            en;
	logic            vreq_valid_s1;
	logic [15:0]     vreq_phi_s1;
	logic [15:0]     vreq_theta_s1;
	usph_pkg::vtag_t vreq_tag_s1;
	logic            trig_valid;
	usph_pkg::vtag_t trig_tag;
	usph_pkg::trig_t trig_val;
	logic            pipe_valid;
	vout_t           pipe_out;
	logic            pipe_take;
	logic            out_v_q;
	vout_t           out_q;
	logic            skid_v_q;
	vout_t           skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= 31'd65536;
			cfg_q.az_step <= 16'd16384;
			cfg_q.polar_step <= 16'd16384;
			cfg_q.slice_count <= 11'd4;
			cfg_q.stack_count <= 11'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				usph_pkg::REG_RADIUS:       cfg_q.radius <= cfg_data;
				usph_pkg::REG_AZIMUTH_STEP: cfg_q.az_step <= cfg_data[15:0];
				usph_pkg::REG_POLAR_STEP:   cfg_q.polar_step <= cfg_data[15:0];
				usph_pkg::REG_SLICE_COUNT:  cfg_q.slice_count <= cfg_data[10:0];
				usph_pkg::REG_STACK_COUNT:  cfg_q.stack_count <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// pipeline moves unless the skid holds a vertex
	assign en = ~skid_v_q;

	usph_expand u_expand (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.slice_index   (slice_index),
		.band_index    (band_index),
		.vreq_valid_s1 (vreq_valid_s1),
		.vreq_phi_s1   (vreq_phi_s1),
		.vreq_theta_s1 (vreq_theta_s1),
		.vreq_tag_s1   (vreq_tag_s1)
	);

	usph_trig u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vreq_valid_s1),
		.in_phi    (vreq_phi_s1),
		.in_theta  (vreq_theta_s1),
		.in_tag    (vreq_tag_s1),
		.out_valid (trig_valid),
		.out_tag   (trig_tag),
		.out_trig  (trig_val)
	);

	usph_coord u_coord (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.radius    (cfg_q.radius),
		.in_valid  (trig_valid),
		.in_tag    (trig_tag),
		.in_trig   (trig_val),
		.out_valid (pipe_valid),
		.out_tag   (pipe_out.tag),
		.out_x     (pipe_out.x),
		.out_y     (pipe_out.y),
		.out_z     (pipe_out.z)
	);

	assign pipe_take = pipe_valid & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_take;
			end
		end else if (pipe_take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : pipe_out;
		end else if (pipe_take) begin
			skid_q <= pipe_out;
		end
	end

	assign out_valid = out_v_q;
	assign vertex_x = out_q.x;
	assign vertex_y = out_q.y;
	assign vertex_z = out_q.z;
	assign last_vertex = out_q.tag.last;
	assign index_error = out_q.tag.err;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a vertex while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ready))
		else $error("skid filled without an output stall");

	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !skid_v_q)
		else $error("input taken while the pipeline is frozen");

	a_err_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.tag.err) |->
			(out_q.tag.last && out_q.x == 32'sd0 && out_q.y == 32'sd0 && out_q.z == 32'sd0))
		else $error("rejected cell did not give a single zero vertex");

endmodule

### rtl/usph_expand.sv
// input stage: checks the cell index and issues one vertex angle pair per cycle while en is high
module usph_expand (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  usph_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [9:0]         slice_index,
	input  logic [9:0]         band_index,
	output logic               vreq_valid_s1,
	output logic [15:0]        vreq_phi_s1,
	output logic [15:0]        vreq_theta_s1,
	output usph_pkg::vtag_t    vreq_tag_s1
);

	// bit k set: vertex k takes the second latitude / the second longitude
	localparam logic [5:0] TOP_PHI_SEL = 6'b000110;
	localparam logic [5:0] TOP_TH_SEL  = 6'b000100;
	localparam logic [5:0] BOT_PHI_SEL = 6'b000110;
	localparam logic [5:0] BOT_TH_SEL  = 6'b000010;
	localparam logic [5:0] MID_PHI_SEL = 6'b011010;
	localparam logic [5:0] MID_TH_SEL  = 6'b110100;
	localparam logic [2:0] LAST_ERR = 3'd0;
	localparam logic [2:0] LAST_CAP = 3'd2;
	localparam logic [2:0] LAST_MID = 3'd5;

	logic [10:0] ns;
	logic [10:0] nb;
	logic        in_err;
	logic        is_top;
	logic        is_bot;
	logic [25:0] t0_full;
	logic [25:0] bp_full;
	logic [15:0] t0;
	logic [15:0] t1;
	logic [15:0] mid_hi;
	logic [15:0] nxt_phi_a;
	logic [15:0] nxt_phi_b;
	logic [5:0]  nxt_phi_sel;
	logic [5:0]  nxt_th_sel;
	logic [2:0]  nxt_last;

	logic        item_v_q;
	logic [2:0]  k_q;
	logic [2:0]  last_k_q;
	logic [15:0] phi_a_q;
	logic [15:0] phi_b_q;
	logic [15:0] th0_q;
	logic [15:0] th1_q;
	logic [5:0]  phi_sel_q;
	logic [5:0]  th_sel_q;
	logic        err_q;
	logic        fin;
	logic        take;

	always_comb begin
		ns = (cfg.slice_count > usph_pkg::MAX_DIVISIONS) ? usph_pkg::MAX_DIVISIONS
			: cfg.slice_count;
		nb = (cfg.stack_count > usph_pkg::MAX_DIVISIONS) ? usph_pkg::MAX_DIVISIONS
			: cfg.stack_count;
		in_err = ({1'b0, slice_index} >= ns) || ({1'b0, band_index} >= nb);
		is_top = (band_index == 10'd0);
		is_bot = ({1'b0, band_index} == (nb - 11'd1));
		t0_full = slice_index * cfg.az_step;
		bp_full = band_index * cfg.polar_step;
		t0 = t0_full[15:0];
		t1 = t0 + cfg.az_step;
		mid_hi = usph_pkg::QTR_TURN - bp_full[15:0];
		if (in_err) begin
			nxt_phi_a = usph_pkg::QTR_TURN;
			nxt_phi_b = usph_pkg::QTR_TURN;
			nxt_phi_sel = '0;
			nxt_th_sel = '0;
			nxt_last = LAST_ERR;
		end else if (is_top) begin
			nxt_phi_a = usph_pkg::QTR_TURN;
			nxt_phi_b = usph_pkg::QTR_TURN - cfg.polar_step;
			nxt_phi_sel = TOP_PHI_SEL;
			nxt_th_sel = TOP_TH_SEL;
			nxt_last = LAST_CAP;
		end else if (is_bot) begin
			nxt_phi_a = usph_pkg::THREE_QTR;
			nxt_phi_b = usph_pkg::THREE_QTR + cfg.polar_step;
			nxt_phi_sel = BOT_PHI_SEL;
			nxt_th_sel = BOT_TH_SEL;
			nxt_last = LAST_CAP;
		end else begin
			nxt_phi_a = mid_hi;
			nxt_phi_b = mid_hi - cfg.polar_step;
			nxt_phi_sel = MID_PHI_SEL;
			nxt_th_sel = MID_TH_SEL;
			nxt_last = LAST_MID;
		end
	end

	assign fin = (k_q == last_k_q);
	assign in_ready = en & (~item_v_q | fin);
	assign take = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
			k_q <= 3'd0;
			vreq_valid_s1 <= 1'b0;
		end else if (en) begin
			vreq_valid_s1 <= item_v_q;
			if (take) begin
				item_v_q <= 1'b1;
				k_q <= 3'd0;
			end else if (item_v_q) begin
				k_q <= k_q + 3'd1;
				if (fin) begin
					item_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			phi_a_q <= nxt_phi_a;
			phi_b_q <= nxt_phi_b;
			th0_q <= t0;
			th1_q <= t1;
			phi_sel_q <= nxt_phi_sel;
			th_sel_q <= nxt_th_sel;
			last_k_q <= nxt_last;
			err_q <= in_err;
		end
		if (en) begin
			vreq_phi_s1 <= phi_sel_q[k_q] ? phi_b_q : phi_a_q;
			vreq_theta_s1 <= th_sel_q[k_q] ? th1_q : th0_q;
			vreq_tag_s1.last <= fin;
			vreq_tag_s1.err <= err_q;
		end
	end

endmodule

### rtl/usph_trig.sv
// pipelined sine and cosine of latitude and longitude, series evaluated in four lanes
module usph_trig (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [15:0]       in_phi,
	input  logic [15:0]       in_theta,
	input  usph_pkg::vtag_t   in_tag,
	output logic              out_valid,
	output usph_pkg::vtag_t   out_tag,
	output usph_pkg::trig_t   out_trig
);

	localparam int LANES = 4;
	localparam int LANE_COS_PHI = 0;
	localparam int LANE_SIN_PHI = 1;
	localparam int LANE_SIN_THETA = 2;
	localparam int LANE_COS_THETA = 3;
	localparam int QS = usph_pkg::QTR_SHIFT;
	localparam int AW = QS + 1;
	localparam int NR = usph_pkg::NUM_ROUNDS;

	typedef struct packed {
		logic [30:0] xq;
		logic [31:0] x2;
		logic        neg;
	} lane_t;

	logic [LANES-1:0][15:0]    ang;
	logic [LANES-1:0][AW-1:0]  arg;
	logic [LANES-1:0]          neg;
	logic [LANES-1:0][AW+30:0] xprod;
	logic [LANES-1:0][61:0]    sq;
	logic [LANES-1:0][61:0]    vp;
	logic [LANES-1:0][31:0]    rsum;
	logic [LANES-1:0][16:0]    rq;
	logic [LANES-1:0][14:0]    smag;

	logic [LANES-1:0][AW-1:0]  arg_s1;
	logic [LANES-1:0]          neg_s1;
	logic                      v_s1;
	usph_pkg::vtag_t           tag_s1;
	logic [LANES-1:0][30:0]    xq_s2;
	logic [LANES-1:0]          neg_s2;
	logic                      v_s2;
	usph_pkg::vtag_t           tag_s2;
	lane_t [LANES-1:0]         c_s3;
	logic                      v_s3;
	usph_pkg::vtag_t           tag_s3;
	logic [LANES-1:0][30:0]    v4_s4;
	logic [LANES-1:0]          neg_s4;
	logic                      v_s4;
	usph_pkg::vtag_t           tag_s4;
	logic [LANES-1:0][15:0]    sin_s5;
	logic                      v_s5;
	usph_pkg::vtag_t           tag_s5;

	lane_t [LANES-1:0]         rc [NR+1];
	logic                      rv [NR+1];
	usph_pkg::vtag_t           rtag [NR+1];
	logic [LANES-1:0][30:0]    rt [NR];

	// quadrant fold
	always_comb begin
		ang[LANE_COS_PHI] = in_phi + usph_pkg::QTR_TURN;
		ang[LANE_SIN_PHI] = in_phi;
		ang[LANE_SIN_THETA] = in_theta;
		ang[LANE_COS_THETA] = in_theta + usph_pkg::QTR_TURN;
		for (int l = 0; l < LANES; l++) begin
			neg[l] = ang[l][QS+1];
			if (ang[l][QS]) begin
				arg[l] = usph_pkg::QTR_TURN[AW-1:0] - AW'(ang[l][QS-1:0]);
			end else begin
				arg[l] = AW'(ang[l][QS-1:0]);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			xprod[l] = arg_s1[l] * usph_pkg::HALF_PI_Q30;
			sq[l] = xq_s2[l] * xq_s2[l];
			vp[l] = rc[NR][l].xq * rt[NR-1][l];
			rsum[l] = {1'b0, v4_s4[l]} + 32'd16384;
			rq[l] = rsum[l][31:15];
			smag[l] = (rq[l] > 17'd32767) ? 15'h7fff : rq[l][14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= rv[NR];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1 <= arg;
			neg_s1 <= neg;
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= rtag[NR];
			tag_s5 <= tag_s4;
			neg_s2 <= neg_s1;
			for (int l = 0; l < LANES; l++) begin
				xq_s2[l] <= xprod[l][QS+30:QS];
				c_s3[l].xq <= xq_s2[l];
				c_s3[l].x2 <= sq[l][61:30];
				c_s3[l].neg <= neg_s2[l];
				v4_s4[l] <= vp[l][60:30];
				neg_s4[l] <= rc[NR][l].neg;
				sin_s5[l] <= neg_s4[l] ? 16'(-{1'b0, smag[l]}) : {1'b0, smag[l]};
			end
		end
	end

	assign rc[0] = c_s3;
	assign rv[0] = v_s3;
	assign rtag[0] = tag_s3;

	// one round: t = 1 - (x2 * t) / d, reciprocal multiply then one-step fix
	for (genvar i = 0; i < NR; i++) begin : g_round
		localparam int SHF = usph_pkg::RND_SHIFT[i];
		localparam logic [63:0] DIVW = 64'(usph_pkg::RND_DIV[i]);
		localparam logic [63:0] MULW = (64'd1 << SHF) / DIVW;

		logic [LANES-1:0][31:0] y;
		logic [LANES-1:0][63:0] qp;
		logic [LANES-1:0][31:0] qd;
		logic [LANES-1:0][31:0] rr;
		logic [LANES-1:0][31:0] qc;

		logic [LANES-1:0][31:0] y_sa;
		lane_t [LANES-1:0]      c_sa;
		logic                   v_sa;
		usph_pkg::vtag_t        tag_sa;
		logic [LANES-1:0][31:0] y_sb;
		logic [LANES-1:0][31:0] qe_sb;
		lane_t [LANES-1:0]      c_sb;
		logic                   v_sb;
		usph_pkg::vtag_t        tag_sb;
		logic [LANES-1:0][30:0] t_sc;
		lane_t [LANES-1:0]      c_sc;
		logic                   v_sc;
		usph_pkg::vtag_t        tag_sc;

		if (i == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					y[l] = rc[i][l].x2;
				end
			end
		end else begin : g_next
			logic [LANES-1:0][62:0] yp;
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					yp[l] = rc[i][l].x2 * rt[i-1][l];
					y[l] = yp[l][61:30];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				qp[l] = y_sa[l] * MULW[31:0];
				qd[l] = qe_sb[l] * DIVW[31:0];
				rr[l] = y_sb[l] - qd[l];
				qc[l] = qe_sb[l] + 32'(rr[l] >= DIVW[31:0]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sa <= 1'b0;
				v_sb <= 1'b0;
				v_sc <= 1'b0;
			end else if (en) begin
				v_sa <= rv[i];
				v_sb <= v_sa;
				v_sc <= v_sb;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				y_sa <= y;
				c_sa <= rc[i];
				tag_sa <= rtag[i];
				y_sb <= y_sa;
				c_sb <= c_sa;
				tag_sb <= tag_sa;
				c_sc <= c_sb;
				tag_sc <= tag_sb;
				for (int l = 0; l < LANES; l++) begin
					qe_sb[l] <= 32'(qp[l] >> SHF);
					t_sc[l] <= usph_pkg::ONE_Q30 - qc[l][30:0];
				end
			end
		end

		assign rc[i+1] = c_sc;
		assign rv[i+1] = v_sc;
		assign rtag[i+1] = tag_sc;
		assign rt[i] = t_sc;
	end

	assign out_valid = v_s5;
	assign out_tag = tag_s5;
	assign out_trig.cos_phi = sin_s5[LANE_COS_PHI];
	assign out_trig.sin_phi = sin_s5[LANE_SIN_PHI];
	assign out_trig.sin_theta = sin_s5[LANE_SIN_THETA];
	assign out_trig.cos_theta = sin_s5[LANE_COS_THETA];

endmodule

### rtl/usph_coord.sv
// scales the trig products by the radius and rounds to q16.16 coordinates
module usph_coord (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [30:0]        radius,
	input  logic               in_valid,
	input  usph_pkg::vtag_t    in_tag,
	input  usph_pkg::trig_t    in_trig,
	output logic               out_valid,
	output usph_pkg::vtag_t    out_tag,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);

	function automatic logic [14:0] mag15(input logic signed [15:0] v);
		logic [15:0] n;
		n = 16'(-v);
		mag15 = v[15] ? n[14:0] : v[14:0];
	endfunction

	logic [14:0] a_cp;
	logic [14:0] a_st;
	logic [14:0] a_ct;
	logic [29:0] mx;
	logic [29:0] mz;
	logic [45:0] yprod;
	logic [45:0] yrnd;
	logic [61:0] xs;
	logic [61:0] zs;

	logic [29:0] mx_s1;
	logic [29:0] mz_s1;
	logic [14:0] my_s1;
	logic        nx_s1;
	logic        ny_s1;
	logic        nz_s1;
	logic        v_s1;
	usph_pkg::vtag_t tag_s1;
	logic [44:0] xh_s2;
	logic [45:0] xl_s2;
	logic [44:0] zh_s2;
	logic [45:0] zl_s2;
	logic [30:0] ym_s2;
	logic        nx_s2;
	logic        ny_s2;
	logic        nz_s2;
	logic        v_s2;
	usph_pkg::vtag_t tag_s2;
	logic [30:0] xm_s3;
	logic [30:0] ym_s3;
	logic [30:0] zm_s3;
	logic        nx_s3;
	logic        ny_s3;
	logic        nz_s3;
	logic        v_s3;
	usph_pkg::vtag_t tag_s3;
	logic [31:0] x_s4;
	logic [31:0] y_s4;
	logic [31:0] z_s4;
	logic        v_s4;
	usph_pkg::vtag_t tag_s4;

	always_comb begin
		a_cp = mag15(in_trig.cos_phi);
		a_st = mag15(in_trig.sin_theta);
		a_ct = mag15(in_trig.cos_theta);
		mx = a_cp * a_st;
		mz = a_cp * a_ct;
		yprod = radius * my_s1;
		yrnd = yprod + 46'd16384;
		xs = 62'({xh_s2, 16'd0}) + 62'(xl_s2) + (62'd1 << 29);
		zs = 62'({zh_s2, 16'd0}) + 62'(zl_s2) + (62'd1 << 29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx;
			mz_s1 <= mz;
			my_s1 <= mag15(in_trig.sin_phi);
			nx_s1 <= in_trig.cos_phi[15] ^ in_trig.sin_theta[15];
			nz_s1 <= in_trig.cos_phi[15] ^ in_trig.cos_theta[15];
			ny_s1 <= in_trig.sin_phi[15];
			tag_s1 <= in_tag;

			xh_s2 <= radius[30:16] * mx_s1;
			xl_s2 <= radius[15:0] * mx_s1;
			zh_s2 <= radius[30:16] * mz_s1;
			zl_s2 <= radius[15:0] * mz_s1;
			ym_s2 <= yrnd[45:15];
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			nz_s2 <= nz_s1;
			tag_s2 <= tag_s1;

			xm_s3 <= xs[60:30];
			zm_s3 <= zs[60:30];
			ym_s3 <= ym_s2;
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			nz_s3 <= nz_s2;
			tag_s3 <= tag_s2;

			// rejected cell gives a zero vertex
			if (tag_s3.err) begin
				x_s4 <= '0;
				y_s4 <= '0;
				z_s4 <= '0;
			end else begin
				x_s4 <= nx_s3 ? 32'(-{1'b0, xm_s3}) : {1'b0, xm_s3};
				y_s4 <= ny_s3 ? 32'(-{1'b0, ym_s3}) : {1'b0, ym_s3};
				z_s4 <= nz_s3 ? 32'(-{1'b0, zm_s3}) : {1'b0, zm_s3};
			end
			tag_s4 <= tag_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_tag = tag_s4;
	assign out_x = x_s4;
	assign out_y = y_s4;
	assign out_z = z_s4;

endmodule
